@@ hw/rtl/spd_pkg.sv @@
// sensor packet decoder package: row storage constants, command and status types
// and the byte-wise crc-8 step shared by the datapath
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package spd_pkg;

   // row storage
   localparam int MAX_ROWS = 16;
   localparam int IDX_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CNT_W    = $clog2(MAX_ROWS + 1);

   // row word fields: length, 65th bit, first 64 bits
   localparam int HEAD_W   = 64;
   localparam int LEN_W    = 7;
   localparam int ROW_W    = LEN_W + 1 + HEAD_W;

   // crc-8, polynomial 0x31, initial value 0
   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'h00;

   // row lengths of interest
   localparam logic [LEN_W-1:0] CLOCK_MIN_LEN = 7'd65;
   localparam logic [LEN_W-1:0] SENSOR_LEN_A  = 7'd48;
   localparam logic [LEN_W-1:0] SENSOR_LEN_B  = 7'd49;

   localparam logic [11:0] YEAR_BASE = 12'd2000;

   // result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_ROW   = 2'd1;
   localparam logic [1:0] ST_ALL_ONES = 2'd2;
   localparam logic [1:0] ST_CRC_BAD  = 2'd3;

   // datapath operations issued by the controller
   typedef enum logic [2:0] {
      OP_NOP   = 3'd0,
      OP_LOAD  = 3'd1,
      OP_CMP   = 3'd2,
      OP_STORE = 3'd3,
      OP_FIND  = 3'd4,
      OP_CRC   = 3'd5,
      OP_EMIT  = 3'd6
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic crc_done;
      logic is_final;
   } stat_type;

   // one byte through the crc, msb first
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] r;
      r = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (r[7]) begin
            r = {r[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            r = {r[6:0], 1'b0};
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/spd_ram.sv @@
// generic single-write, single-read ram with registered read data
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

module spd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

@@ hw/rtl/spd_ctrl.sv @@
// sensor packet decoder controller: sequences load, compare sweep, store
// for each item, and search sweep, crc and result for a final item
// depends on spd_pkg
`timescale 1ns / 1ps
`default_nettype none

module spd_ctrl
   import spd_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   input  wire stat_type stat,
   output cmd_type       cmd,
   output logic          busy
);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_CMP   = 6'b000010,
      S_STORE = 6'b000100,
      S_FIND  = 6'b001000,
      S_CRC   = 6'b010000,
      S_EMIT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // next state and command
   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NOP;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op   = OP_LOAD;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            cmd.op = OP_CMP;
            if (stat.scan_done) begin
               state_in = S_STORE;
            end
         end
         S_STORE: begin
            cmd.op   = OP_STORE;
            state_in = stat.is_final ? S_FIND : S_IDLE;
         end
         S_FIND: begin
            cmd.op = OP_FIND;
            if (stat.scan_done) begin
               state_in = S_CRC;
            end
         end
         S_CRC: begin
            cmd.op = OP_CRC;
            if (stat.crc_done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            cmd.op   = OP_EMIT;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

`default_nettype wire

@@ hw/rtl/spd_datapath.sv @@
// sensor packet decoder datapath: row ram, repeat marks, sweep counter,
// captured clock and sensor rows, crc units and result registers
// depends on spd_pkg and spd_ram
`timescale 1ns / 1ps
`default_nettype none

module spd_datapath
   import spd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmd_type            cmd,
   output stat_type                stat,
   input  wire logic [HEAD_W-1:0]  req_row_head,
   input  wire logic               req_row_bit_extra,
   input  wire logic [LEN_W-1:0]   req_row_length,
   input  wire logic               req_final_row,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_status,
   output logic [11:0]             rsp_sensor_id,
   output logic [3:0]              rsp_channel,
   output logic                    rsp_batt_good,
   output logic signed [9:0]       rsp_temp_tenths,
   output logic [7:0]              rsp_humidity,
   output logic                    rsp_clock_valid,
   output logic [11:0]             rsp_clock_year,
   output logic [3:0]              rsp_clock_month,
   output logic [4:0]              rsp_clock_day,
   output logic [16:0]             rsp_clock_hms
);

   // current item
   logic [ROW_W-1:0]  cur_ff, cur_in;
   logic              final_ff, final_in;
   logic [HEAD_W-1:0] head_mask;

   // transmission state
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [MAX_ROWS-1:0] marks_ff, marks_in;

   // sweep
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0] limit;
   logic             room;

   // ram ports
   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr;
   logic [IDX_W-1:0] ram_raddr;
   logic [ROW_W-1:0] ram_rdata;
   logic [LEN_W-1:0] rd_len;

   // captured rows and crc
   logic [HEAD_W-1:0] clk_row_ff, clk_row_in, sen_row_ff, sen_row_in;
   logic              clk_found_ff, clk_found_in, sen_found_ff, sen_found_in;
   logic              clk_nz_ff, clk_nz_in;
   logic [7:0]        clk_crc_ff, clk_crc_in, sen_crc_ff, sen_crc_in;
   logic [2:0]        byte_ff, byte_in;

   // result fields
   logic [7:0]  cb [8];
   logic [7:0]  sb [8];
   logic        cv;
   logic [1:0]  st;
   logic        rv_in;
   logic [1:0]  st_in;
   logic [11:0] id_in;
   logic [3:0]  ch_in;
   logic        bat_in;
   logic [9:0]  temp_in;
   logic [7:0]  hum_in;
   logic        cv_in;
   logic [11:0] yr_in;
   logic [3:0]  mo_in;
   logic [4:0]  dy_in;
   logic [16:0] hms_in;

   // keep only the first row_length bits of the inverted head
   always_comb begin
      for (int j = 0; j < HEAD_W; j++) begin
         head_mask[HEAD_W-1-j] = (req_row_length > LEN_W'(j));
      end
   end

   assign room  = (count_ff < CNT_W'(MAX_ROWS));
   assign limit = (cmd.op == OP_CMP) ? (room ? count_ff : '0) : count_ff;

   assign rd_len = ram_rdata[ROW_W-1 -: LEN_W];

   spd_ram #(
      .WIDTH(ROW_W),
      .DEPTH(MAX_ROWS)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(cur_ff),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign ram_raddr = idx_ff[IDX_W-1:0];
   assign ram_waddr = count_ff[IDX_W-1:0];
   assign ram_we    = (cmd.op == OP_STORE) && room;

   // byte views of the captured rows
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         cb[k] = clk_row_ff[HEAD_W-1-8*k -: 8];
         sb[k] = sen_row_ff[HEAD_W-1-8*k -: 8];
      end
   end

   // result decode
   always_comb begin
      cv = clk_found_ff && clk_nz_ff && (clk_crc_ff == 8'h00);
      if (!sen_found_ff) begin
         st = ST_NO_ROW;
      end else if (sb[0] == 8'h00 && sb[1] == 8'h00 && sb[2] == 8'h00 && sb[4] == 8'h00) begin
         st = ST_ALL_ONES;
      end else if (sen_crc_ff != 8'h00) begin
         st = ST_CRC_BAD;
      end else begin
         st = ST_OK;
      end
   end

   // sequencing of the datapath operations
   always_comb begin
      cur_in       = cur_ff;
      final_in     = final_ff;
      count_in     = count_ff;
      marks_in     = marks_ff;
      idx_in       = idx_ff;
      pend_in      = 1'b0;
      rd_idx_in    = idx_ff[IDX_W-1:0];
      clk_row_in   = clk_row_ff;
      sen_row_in   = sen_row_ff;
      clk_found_in = clk_found_ff;
      sen_found_in = sen_found_ff;
      clk_nz_in    = clk_nz_ff;
      clk_crc_in   = clk_crc_ff;
      sen_crc_in   = sen_crc_ff;
      byte_in      = byte_ff;
      rv_in        = 1'b0;

      case (cmd.op)
         OP_LOAD: begin
            cur_in       = {req_row_length,
                            (~req_row_bit_extra) & (req_row_length >= CLOCK_MIN_LEN),
                            (~req_row_head) & head_mask};
            final_in     = req_final_row;
            idx_in       = '0;
            clk_found_in = 1'b0;
            sen_found_in = 1'b0;
            clk_nz_in    = 1'b0;
            clk_crc_in   = CRC_INIT;
            sen_crc_in   = CRC_INIT;
            byte_in      = '0;
         end
         OP_CMP, OP_FIND: begin
            // issue the next read
            if (idx_ff < limit) begin
               pend_in = 1'b1;
               idx_in  = idx_ff + CNT_W'(1);
            end
            // act on the row read last cycle
            if (pend_ff) begin
               if (cmd.op == OP_CMP) begin
                  if (ram_rdata == cur_ff) begin
                     marks_in[rd_idx_ff] = 1'b1;
                  end
               end else if (marks_ff[rd_idx_ff]) begin
                  if (!clk_found_ff && rd_len >= CLOCK_MIN_LEN) begin
                     clk_found_in = 1'b1;
                     clk_nz_in    = (rd_idx_ff != '0);
                     clk_row_in   = ram_rdata[HEAD_W-1:0];
                  end
                  if (!sen_found_ff && (rd_len == SENSOR_LEN_A || rd_len == SENSOR_LEN_B)) begin
                     sen_found_in = 1'b1;
                     sen_row_in   = ram_rdata[HEAD_W-1:0];
                  end
               end
            end
         end
         OP_STORE: begin
            idx_in = '0;
            if (room) begin
               marks_in[count_ff[IDX_W-1:0]] = 1'b0;
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_CRC: begin
            // one byte per cycle; after all eight bytes the rows are back in order
            clk_crc_in = crc8_byte(clk_crc_ff, clk_row_ff[HEAD_W-1 -: 8]);
            if (byte_ff < 3'd6) begin
               sen_crc_in = crc8_byte(sen_crc_ff, sen_row_ff[HEAD_W-1 -: 8]);
            end
            clk_row_in = {clk_row_ff[HEAD_W-9:0], clk_row_ff[HEAD_W-1 -: 8]};
            sen_row_in = {sen_row_ff[HEAD_W-9:0], sen_row_ff[HEAD_W-1 -: 8]};
            byte_in    = byte_ff + 3'd1;
         end
         OP_EMIT: begin
            rv_in    = 1'b1;
            count_in = '0;
            marks_in = '0;
         end
         default: begin
         end
      endcase
   end

   // result fields
   always_comb begin
      st_in   = st;
      id_in   = '0;
      ch_in   = '0;
      bat_in  = 1'b0;
      temp_in = '0;
      hum_in  = '0;
      if (st == ST_OK) begin
         ch_in   = {1'b0, sb[0][6:4]} + 4'd1;
         id_in   = {sb[0][3:0], sb[1]};
         bat_in  = ~sb[2][7];
         temp_in = {sb[2][5:0], sb[3][7:4]};
         hum_in  = {1'b0, sb[4][7:4], 3'b000} + {3'b000, sb[4][7:4], 1'b0}
                   + {4'b0000, sb[4][3:0]};
      end
      cv_in  = cv;
      yr_in  = '0;
      mo_in  = '0;
      dy_in  = '0;
      hms_in = '0;
      if (cv) begin
         hms_in = {cb[2][4:0], cb[3][5:0], cb[4][5:0]};
         yr_in  = YEAR_BASE + {5'b00000, cb[5][7:1]};
         dy_in  = {cb[5][0], cb[6][7:4]};
         mo_in  = cb[6][3:0];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         marks_ff  <= '0;
         pend_ff   <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         count_ff  <= count_in;
         marks_ff  <= marks_in;
         pend_ff   <= pend_in;
         rsp_valid <= rv_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      final_ff     <= final_in;
      idx_ff       <= idx_in;
      rd_idx_ff    <= rd_idx_in;
      clk_row_ff   <= clk_row_in;
      sen_row_ff   <= sen_row_in;
      clk_found_ff <= clk_found_in;
      sen_found_ff <= sen_found_in;
      clk_nz_ff    <= clk_nz_in;
      clk_crc_ff   <= clk_crc_in;
      sen_crc_ff   <= sen_crc_in;
      byte_ff      <= byte_in;
      if (rv_in) begin
         rsp_status      <= st_in;
         rsp_sensor_id   <= id_in;
         rsp_channel     <= ch_in;
         rsp_batt_good   <= bat_in;
         rsp_temp_tenths <= temp_in;
         rsp_humidity    <= hum_in;
         rsp_clock_valid <= cv_in;
         rsp_clock_year  <= yr_in;
         rsp_clock_month <= mo_in;
         rsp_clock_day   <= dy_in;
         rsp_clock_hms   <= hms_in;
      end
   end

   // status to the controller
   assign stat.scan_done = !pend_ff && (idx_ff >= limit);
   assign stat.crc_done  = (byte_ff == 3'd7);
   assign stat.is_final  = final_ff;

endmodule

`default_nettype wire

@@ hw/rtl/sensor_packet_decoder.sv @@
// sensor packet decoder top level: controller and datapath
// depends on spd_pkg, spd_ctrl, spd_datapath
//
//   channel   ports                     handshake
//   -------   -----                     ---------
//   request   start, busy, req_*        taken when start is high and busy is low
//   response  rsp_valid, rsp_*          one-cycle strobe, cannot be held off
//
// an item runs from its accept to the next accept through a compare sweep, with one ram
// read per row already stored this transmission and a read drain, then a store; with no
// row stored, or with the store full, the sweep makes no reads.
// a final item adds a search sweep over the M rows then held, a crc over eight bytes
// (one byte per cycle) and a result step; the strobe comes with the return to idle.
// reset clears the row count, repeat marks and the controller; ram contents need no clearing.
`timescale 1ns / 1ps
`default_nettype none

module sensor_packet_decoder
   import spd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [HEAD_W-1:0] req_row_head,
   input  wire logic              req_row_bit_extra,
   input  wire logic [LEN_W-1:0]  req_row_length,
   input  wire logic              req_final_row,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_status,
   output logic [11:0]            rsp_sensor_id,
   output logic [3:0]             rsp_channel,
   output logic                   rsp_batt_good,
   output logic signed [9:0]      rsp_temp_tenths,
   output logic [7:0]             rsp_humidity,
   output logic                   rsp_clock_valid,
   output logic [11:0]            rsp_clock_year,
   output logic [3:0]             rsp_clock_month,
   output logic [4:0]             rsp_clock_day,
   output logic [16:0]            rsp_clock_hms
);

   cmd_type  cmd;
   stat_type stat;

   // sequencing
   spd_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .stat (stat),
      .cmd  (cmd),
      .busy (busy)
   );

   // storage, search and decode
   spd_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_row_head     (req_row_head),
      .req_row_bit_extra(req_row_bit_extra),
      .req_row_length   (req_row_length),
      .req_final_row    (req_final_row),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_sensor_id    (rsp_sensor_id),
      .rsp_channel      (rsp_channel),
      .rsp_batt_good    (rsp_batt_good),
      .rsp_temp_tenths  (rsp_temp_tenths),
      .rsp_humidity     (rsp_humidity),
      .rsp_clock_valid  (rsp_clock_valid),
      .rsp_clock_year   (rsp_clock_year),
      .rsp_clock_month  (rsp_clock_month),
      .rsp_clock_day    (rsp_clock_day),
      .rsp_clock_hms    (rsp_clock_hms)
   );

endmodule

`default_nettype wire
